// ===== sv/ccna_pkg.sv =====
package ccna_pkg;

  // Input transaction codes
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // Result codes
  localparam logic RES_ASSIGN = 1'b0;
  localparam logic RES_READ   = 1'b1;

  // Fixed widths
  localparam int NORM_W  = 40;
  localparam int UNORM_W = 24;
  localparam int SUM_W   = 24;
  localparam int CNT_W   = 22;
  localparam int NUM_W   = SUM_W + 13;
  localparam int MUL_W   = 64;
  localparam int PROD_W  = 2 * MUL_W;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [15:0]      COS_ONE   = 16'd32768;
  localparam logic [5:0]       CNT_RESET = 6'd25;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  cluster;
    logic [11:0] item;
    logic [15:0] centroid_value;
    logic [2:0]  rating;
    logic        last;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [4:0]  assigned_cluster;
    logic [15:0] cosine;
    logic [15:0] averaged_value;
    logic        overflow;
  } out_t;

  // One entry of the per-cluster, per-item accumulator memory
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } acc_t;

endpackage

// ===== sv/cosine_nearest_centroid_assign_unit.sv =====
// Channel  | handshake                | payload
// ---------+--------------------------+---------------------------
// in       | in_valid / in_stall      | in_data  (ccna_pkg::in_t)
// out      | out_valid / out_stall    | out_data (ccna_pkg::out_t)
// cfg      | cfg_valid / cfg_ready    | cfg_data (cluster count)
//
// One transaction at a time. A load reads, squares and writes back. A rating makes
// one centroid store read per cluster. A last rating adds the search, which uses the
// four-step 32x32 multiplier for each later cluster with nonzero norm, the cosine
// search over the 15 bits of q and an update per buffered rating. Readback uses the
// 37-step divider when the count is nonzero. Clear zeroes the accumulators. After
// reset a sweep of all MAX_CLUSTERS*ITEM_COUNT addresses (131072 by default) zeroes
// the stores; in_stall stays high meanwhile.
// A result waits in the output register while out_stall is high.
module cosine_nearest_centroid_assign_unit #(
  parameter int MAX_CLUSTERS = 32,
  parameter int ITEM_COUNT   = 4096,
  parameter int MAX_RATINGS  = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ccna_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ccna_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [5:0]      cfg_data
);
  import ccna_pkg::*;

  localparam int CW    = $clog2(MAX_CLUSTERS);
  localparam int DEPTH = MAX_CLUSTERS * ITEM_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_RATINGS);
  localparam int PCW   = $clog2(MAX_RATINGS + 1);
  localparam int DW    = 19 + PCW;
  localparam int DW2   = 2 * DW;
  localparam int LIM   = (MAX_CLUSTERS < 32) ? MAX_CLUSTERS : 32;
  localparam int AC_W  = SUM_W + CNT_W;

  localparam logic [AW-1:0]  IC_A    = AW'(ITEM_COUNT);
  localparam logic [AW-1:0]  SW_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0]  RC_LAST = CW'(MAX_CLUSTERS - 1);
  localparam logic [PCW-1:0] P_FULL  = PCW'(MAX_RATINGS);

  typedef enum logic [22:0] {
    ST_SWEEP    = 23'h000001,
    ST_IDLE     = 23'h000002,
    ST_LD_RD    = 23'h000004,
    ST_LD_SQ    = 23'h000008,
    ST_LD_WR    = 23'h000010,
    ST_RT_RUN   = 23'h000020,
    ST_RT_DRAIN = 23'h000040,
    ST_FN_RD    = 23'h000080,
    ST_FN_DAT   = 23'h000100,
    ST_FN_SQ    = 23'h000200,
    ST_FN_ML    = 23'h000400,
    ST_FN_MR    = 23'h000800,
    ST_FN_END   = 23'h001000,
    ST_CS_NN    = 23'h002000,
    ST_CS_SQ    = 23'h004000,
    ST_CS_ML    = 23'h008000,
    ST_UP_RD    = 23'h010000,
    ST_UP_ACC   = 23'h020000,
    ST_UP_WR    = 23'h040000,
    ST_RB_RD    = 23'h080000,
    ST_RB_DAT   = 23'h100000,
    ST_RB_DIV   = 23'h200000,
    ST_EMIT     = 23'h400000
  } state_t;

  state_t state;

  // Control and user state
  logic [5:0]         cluster_count;
  logic               sweep_all;
  logic [AW-1:0]      swaddr;
  logic [MAX_CLUSTERS-1:0] dot_vld;
  logic [PCW-1:0]     pcount;
  logic [UNORM_W-1:0] unorm;
  logic               ovf;

  // Working registers
  logic [AW-1:0]      op_addr;
  logic [CW-1:0]      op_cl;
  logic [15:0]        op_val;
  logic [31:0]        sq_new, sq_old;
  logic [AW-1:0]      saddr;
  logic [CW-1:0]      rc;
  logic [2:0]         rt_r;
  logic               last_r;
  logic               p1;
  logic [CW-1:0]      p1idx;
  logic [CW-1:0]      c;
  logic [CW-1:0]      best;
  logic               bvalid;
  logic [NORM_W-1:0]  bnorm, cn_r;
  logic [DW2-1:0]     bsq, dc2;
  logic [PROD_W-1:0]  lhs;
  logic [MUL_W-1:0]   nn;
  logic [14:0]        q, tq;
  logic [3:0]         qb;
  logic [AW-1:0]      base_r;
  logic [AW-1:0]      up_addr;
  logic [2:0]         up_r;
  logic [PCW-1:0]     ui;
  out_t               res;

  // Memories
  logic [15:0]       store_mem [DEPTH];
  logic [NORM_W-1:0] norm_mem  [MAX_CLUSTERS];
  logic [DW-1:0]     dot_mem   [MAX_CLUSTERS];
  logic [AC_W-1:0]   acc_mem   [DEPTH];
  logic [14:0]       pend_mem  [MAX_RATINGS];

  logic              st_re, st_we;
  logic [AW-1:0]     st_ra, st_wa;
  logic [15:0]       st_wd, st_q;
  logic              nm_re, nm_we;
  logic [CW-1:0]     nm_ra, nm_wa;
  logic [NORM_W-1:0] nm_wd, norm_q;
  logic              dt_re, dt_we;
  logic [CW-1:0]     dt_ra, dt_wa;
  logic [DW-1:0]     dt_wd, dot_q;
  logic              dvq;
  logic              ac_re, ac_we;
  logic [AW-1:0]     ac_ra, ac_wa;
  acc_t              ac_wd, ac_q;
  logic              pd_re, pd_we;
  logic [PW-1:0]     pd_ra, pd_wa;
  logic [14:0]       pd_wd, pd_q;

  // Arithmetic units
  logic              mul_start, mul_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_q;

  // Combinational helpers
  logic              in_acc;
  logic              cl_ok, item_ok;
  logic [AW-1:0]     in_addr;
  logic [CW:0]       n_eff;
  logic [CW:0]       c_next;
  logic              fn_last;
  logic              need_cos;
  logic [DW-1:0]     dotv;
  logic [18:0]       rt_prod;
  logic [14:0]       t;
  logic [29:0]       t_sq;
  logic [PROD_W-1:0] cs_rhs;
  logic [14:0]       q_new;
  logic              up_ok;
  logic [SUM_W:0]    up_sum;
  state_t            up_first;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign cl_ok   = (int'(in_data.cluster) < MAX_CLUSTERS);
  assign item_ok = (int'(in_data.item) < ITEM_COUNT);
  assign in_addr = AW'(in_data.cluster) * IC_A + AW'(in_data.item);

  // Clusters searched: clamp to 1..LIM
  always_comb begin
    if (cluster_count == 6'd0) begin
      n_eff = (CW+1)'(1);
    end else if (int'(cluster_count) > LIM) begin
      n_eff = (CW+1)'(LIM);
    end else begin
      n_eff = (CW+1)'(cluster_count);
    end
  end

  assign c_next   = (CW+1)'(c) + (CW+1)'(1);
  assign fn_last  = (c_next == n_eff);
  assign need_cos = bvalid && (unorm != '0);
  assign dotv     = dvq ? dot_q : '0;
  assign rt_prod  = st_q * rt_r;
  assign t        = q | (15'd1 << qb);
  assign t_sq     = t * t;
  assign cs_rhs   = PROD_W'(bsq) << 30;
  assign q_new    = (mul_p <= cs_rhs) ? tq : q;
  assign up_sum   = {1'b0, ac_q.sum} + (SUM_W+1)'(up_r);
  assign up_ok    = (ac_q.cnt < CNT_MAX) && (up_sum <= (SUM_W+1)'(SUM_MAX));
  assign up_first = (pcount == '0) ? ST_EMIT : ST_UP_RD;

  // Memory port control
  always_comb begin
    st_re = 1'b0; st_ra = saddr;  st_we = 1'b0; st_wa = op_addr; st_wd = op_val;
    nm_re = 1'b0; nm_ra = c;      nm_we = 1'b0; nm_wa = op_cl;
    nm_wd = norm_q + NORM_W'(sq_new) - NORM_W'(sq_old);
    dt_re = 1'b0; dt_ra = c;      dt_we = p1;   dt_wa = p1idx;
    dt_wd = dotv + DW'(rt_prod);
    ac_re = 1'b0; ac_ra = op_addr; ac_we = 1'b0; ac_wa = up_addr;
    ac_wd = '{sum: ac_q.sum + SUM_W'(up_r), cnt: ac_q.cnt + CNT_W'(1)};
    pd_re = 1'b0; pd_ra = ui[PW-1:0];
    pd_we = in_acc && (in_data.kind == KIND_RATE) && item_ok && (pcount < P_FULL);
    pd_wa = pcount[PW-1:0];
    pd_wd = {in_data.item, in_data.rating};
    case (state)
      ST_SWEEP: begin
        st_we = sweep_all; st_wa = swaddr; st_wd = '0;
        nm_we = sweep_all && (swaddr < AW'(MAX_CLUSTERS));
        nm_wa = CW'(swaddr); nm_wd = '0;
        ac_we = 1'b1; ac_wa = swaddr; ac_wd = '0;
      end
      ST_LD_RD: begin
        st_re = 1'b1; st_ra = op_addr;
        nm_re = 1'b1; nm_ra = op_cl;
      end
      ST_LD_WR: begin
        st_we = 1'b1;
        nm_we = 1'b1;
      end
      ST_RT_RUN: begin
        st_re = 1'b1;
        dt_re = 1'b1; dt_ra = rc;
      end
      ST_FN_RD: begin
        nm_re = 1'b1;
        dt_re = 1'b1;
      end
      ST_UP_RD: begin
        pd_re = 1'b1;
      end
      ST_UP_ACC: begin
        ac_re = 1'b1; ac_ra = base_r + AW'(pd_q[14:3]);
      end
      ST_UP_WR: begin
        ac_we = up_ok;
      end
      ST_RB_RD: begin
        ac_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Centroid store
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    if (st_re) begin
      st_q <= store_mem[st_ra];
    end
  end

  // Centroid squared norms
  always_ff @(posedge clk) begin
    if (nm_we) begin
      norm_mem[nm_wa] <= nm_wd;
    end
    if (nm_re) begin
      norm_q <= norm_mem[nm_ra];
    end
  end

  // Per-cluster dot products of the current user
  always_ff @(posedge clk) begin
    if (dt_we) begin
      dot_mem[dt_wa] <= dt_wd;
    end
    if (dt_re) begin
      dot_q <= dot_mem[dt_ra];
      dvq   <= dot_vld[dt_ra];
    end
  end

  // Rating sums and counts
  always_ff @(posedge clk) begin
    if (ac_we) begin
      acc_mem[ac_wa] <= ac_wd;
    end
    if (ac_re) begin
      ac_q <= acc_mem[ac_ra];
    end
  end

  // Buffered ratings of the current user
  always_ff @(posedge clk) begin
    if (pd_we) begin
      pend_mem[pd_wa] <= pd_wd;
    end
    if (pd_re) begin
      pd_q <= pend_mem[pd_ra];
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_start = 1'b0;
    mul_a     = MUL_W'(dc2);
    mul_b     = MUL_W'(bnorm);
    case (state)
      ST_FN_SQ: begin
        mul_start = bvalid;
      end
      ST_FN_ML: begin
        mul_start = mul_done;
        mul_a     = MUL_W'(bsq);
        mul_b     = MUL_W'(cn_r);
      end
      ST_FN_END: begin
        mul_start = need_cos;
        mul_a     = MUL_W'(bnorm);
        mul_b     = MUL_W'(unorm);
      end
      ST_CS_SQ: begin
        mul_start = 1'b1;
        mul_a     = nn;
        mul_b     = MUL_W'(t_sq);
      end
      default: begin
      end
    endcase
  end

  assign div_start = (state == ST_RB_DAT) && (ac_q.cnt != '0);

  ccna_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  ccna_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({ac_q.sum, 13'd0}),
    .den   (ac_q.cnt),
    .done  (div_done),
    .quo   (div_q)
  );

  // Dot loop pipeline: write-back follows the read in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
    end else begin
      p1 <= (state == ST_RT_RUN);
    end
    p1idx <= rc;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      sweep_all     <= 1'b1;
      swaddr        <= '0;
      dot_vld       <= '0;
      pcount        <= '0;
      unorm         <= '0;
      ovf           <= 1'b0;
      cluster_count <= CNT_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cluster_count <= cfg_data;
      end
      // a result taken while a new one is emitted is replaced in ST_EMIT
      if (out_valid && !out_stall && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      if (dt_we) begin
        dot_vld[dt_wa] <= 1'b1;
      end

      case (state)
        ST_SWEEP: begin
          swaddr <= swaddr + AW'(1);
          if (swaddr == SW_LAST) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            case (in_data.kind)
              KIND_LOAD: begin
                if (cl_ok && item_ok) begin
                  op_addr <= in_addr;
                  op_cl   <= CW'(in_data.cluster);
                  op_val  <= in_data.centroid_value;
                  state   <= ST_LD_RD;
                end
              end
              KIND_RATE: begin
                c      <= '0;
                best   <= '0;
                bvalid <= 1'b0;
                if (item_ok && (pcount < P_FULL)) begin
                  pcount <= pcount + PCW'(1);
                  unorm  <= unorm + UNORM_W'(in_data.rating) * UNORM_W'(in_data.rating);
                  rt_r   <= in_data.rating;
                  saddr  <= AW'(in_data.item);
                  rc     <= '0;
                  last_r <= in_data.last;
                  state  <= ST_RT_RUN;
                end else begin
                  if (item_ok) begin
                    ovf <= 1'b1;
                  end
                  if (in_data.last) begin
                    state <= ST_FN_RD;
                  end
                end
              end
              KIND_READ: begin
                res <= '{result_kind: RES_READ, assigned_cluster: in_data.cluster,
                         cosine: 16'd0, averaged_value: 16'd0, overflow: 1'b0};
                if (cl_ok && item_ok) begin
                  op_addr <= in_addr;
                  state   <= ST_RB_RD;
                end else begin
                  state <= ST_EMIT;
                end
              end
              default: begin
                sweep_all <= 1'b0;
                swaddr    <= '0;
                state     <= ST_SWEEP;
              end
            endcase
          end
        end

        // centroid load: read old value and norm, square, write back
        ST_LD_RD: begin
          state <= ST_LD_SQ;
        end
        ST_LD_SQ: begin
          sq_new <= op_val * op_val;
          sq_old <= st_q * st_q;
          state  <= ST_LD_WR;
        end
        ST_LD_WR: begin
          state <= ST_IDLE;
        end

        // rating: one centroid per cycle into the dot products
        ST_RT_RUN: begin
          saddr <= saddr + IC_A;
          rc    <= rc + CW'(1);
          if (rc == RC_LAST) begin
            state <= ST_RT_DRAIN;
          end
        end
        ST_RT_DRAIN: begin
          state <= last_r ? ST_FN_RD : ST_IDLE;
        end

        // search: dot_c^2 * norm_best against dot_best^2 * norm_c
        ST_FN_RD: begin
          state <= ST_FN_DAT;
        end
        ST_FN_DAT: begin
          if (norm_q == '0) begin
            if (fn_last) begin
              state <= ST_FN_END;
            end else begin
              c     <= c + CW'(1);
              state <= ST_FN_RD;
            end
          end else begin
            dc2   <= dotv * dotv;
            cn_r  <= norm_q;
            state <= ST_FN_SQ;
          end
        end
        ST_FN_SQ: begin
          if (bvalid) begin
            state <= ST_FN_ML;
          end else begin
            best   <= c;
            bnorm  <= cn_r;
            bsq    <= dc2;
            bvalid <= 1'b1;
            if (fn_last) begin
              state <= ST_FN_END;
            end else begin
              c     <= c + CW'(1);
              state <= ST_FN_RD;
            end
          end
        end
        ST_FN_ML: begin
          if (mul_done) begin
            lhs   <= mul_p;
            state <= ST_FN_MR;
          end
        end
        ST_FN_MR: begin
          if (mul_done) begin
            if (lhs > mul_p) begin
              best  <= c;
              bnorm <= cn_r;
              bsq   <= dc2;
            end
            if (fn_last) begin
              state <= ST_FN_END;
            end else begin
              c     <= c + CW'(1);
              state <= ST_FN_RD;
            end
          end
        end
        ST_FN_END: begin
          base_r <= AW'(best) * IC_A;
          ui     <= '0;
          res    <= '{result_kind: RES_ASSIGN, assigned_cluster: 5'(best),
                      cosine: 16'd0, averaged_value: 16'd0, overflow: ovf};
          state  <= need_cos ? ST_CS_NN : up_first;
        end

        // cosine: bit-by-bit search of q with nn*q^2 <= dot^2 << 30
        ST_CS_NN: begin
          if (mul_done) begin
            nn <= mul_p[MUL_W-1:0];
            if (mul_p[MUL_W-1:0] <= MUL_W'(bsq)) begin
              res.cosine <= COS_ONE;
              state      <= up_first;
            end else begin
              q     <= '0;
              qb    <= 4'd14;
              state <= ST_CS_SQ;
            end
          end
        end
        ST_CS_SQ: begin
          tq    <= t;
          state <= ST_CS_ML;
        end
        ST_CS_ML: begin
          if (mul_done) begin
            q <= q_new;
            if (qb == 4'd0) begin
              res.cosine <= 16'(q_new);
              state      <= up_first;
            end else begin
              qb    <= qb - 4'd1;
              state <= ST_CS_SQ;
            end
          end
        end

        // fold buffered ratings into the chosen cluster
        ST_UP_RD: begin
          state <= ST_UP_ACC;
        end
        ST_UP_ACC: begin
          up_addr <= base_r + AW'(pd_q[14:3]);
          up_r    <= pd_q[2:0];
          state   <= ST_UP_WR;
        end
        ST_UP_WR: begin
          ui <= ui + PCW'(1);
          if ((ui + PCW'(1)) == pcount) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_UP_RD;
          end
        end

        // readback: sum << 13 over count
        ST_RB_RD: begin
          state <= ST_RB_DAT;
        end
        ST_RB_DAT: begin
          state <= (ac_q.cnt == '0) ? ST_EMIT : ST_RB_DIV;
        end
        ST_RB_DIV: begin
          if (div_done) begin
            res.averaged_value <= div_q[15:0];
            state              <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= res;
            if (res.result_kind == RES_ASSIGN) begin
              dot_vld <= '0;
              unorm   <= '0;
              pcount  <= '0;
              ovf     <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_pcount_bound: assert property (@(posedge clk) disable iff (rst)
    pcount <= P_FULL)
    else $error("rating buffer count beyond capacity");

  a_mul_done_expected: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_FN_ML || state == ST_FN_MR ||
                  state == ST_CS_NN || state == ST_CS_ML))
    else $error("multiplier finished with no state waiting");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_RB_DIV)
    else $error("divider finished outside readback");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

// ===== sv/ccna_mul.sv =====
module ccna_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ccna_pkg::MUL_W-1:0]   a,
  input  logic [ccna_pkg::MUL_W-1:0]   b,
  output logic                         done,
  output logic [ccna_pkg::PROD_W-1:0]  p
);
  import ccna_pkg::*;

  localparam int HW = MUL_W / 2;

  logic [MUL_W-1:0]  a_r, b_r;
  logic [1:0]        ph;
  logic              busy;
  logic              pv;
  logic              plast;
  logic [MUL_W-1:0]  pp;
  logic [1:0]        psh;
  logic [PROD_W-1:0] acc;
  logic [HW-1:0]     a_part, b_part;
  logic [PROD_W-1:0] pp_sh;

  // ph[1] picks the half of a, ph[0] the half of b
  assign a_part = ph[1] ? a_r[MUL_W-1:HW] : a_r[HW-1:0];
  assign b_part = ph[0] ? b_r[MUL_W-1:HW] : b_r[HW-1:0];
  assign pp_sh  = PROD_W'(pp) << (HW * (int'(psh[1]) + int'(psh[0])));

  // four 32x32 partial products, one per cycle, added the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      pv   <= busy;
      if (start) begin
        busy <= 1'b1;
        ph   <= 2'd0;
        a_r  <= a;
        b_r  <= b;
        acc  <= '0;
      end else if (busy) begin
        ph <= ph + 2'd1;
        if (ph == 2'd3) begin
          busy <= 1'b0;
        end
      end
      if (busy) begin
        pp    <= a_part * b_part;
        psh   <= ph;
        plast <= (ph == 2'd3);
      end
      if (pv) begin
        acc <= acc + pp_sh;
        if (plast) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign p = acc;

endmodule

// ===== sv/ccna_div.sv =====
module ccna_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ccna_pkg::NUM_W-1:0]  num,
  input  logic [ccna_pkg::CNT_W-1:0]  den,
  output logic                        done,
  output logic [ccna_pkg::NUM_W-1:0]  quo
);
  import ccna_pkg::*;

  localparam int KW = $clog2(NUM_W);

  logic [NUM_W-1:0] n_r;
  logic [CNT_W-1:0] d_r;
  logic [CNT_W-1:0] rem;
  logic [KW-1:0]    k;
  logic             busy;
  logic [CNT_W:0]   r_sh;
  logic             ge;
  logic [CNT_W-1:0] rem_nx;

  // restoring step: one quotient bit per cycle
  assign r_sh   = {rem, n_r[NUM_W-1]};
  assign ge     = (r_sh >= {1'b0, d_r});
  assign rem_nx = ge ? CNT_W'(r_sh - {1'b0, d_r}) : r_sh[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n_r  <= num;
        d_r  <= den;
        rem  <= '0;
        k    <= KW'(NUM_W - 1);
      end else if (busy) begin
        rem <= rem_nx;
        n_r <= {n_r[NUM_W-2:0], ge};
        k   <= k - KW'(1);
        if (k == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = n_r;

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccna_pkg::*;

  localparam int NCL   = 32;
  localparam int NITEM = 4096;
  localparam int NBUF  = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [5:0] cfg_data = '0;

  bit quiet = 1'b0;
  int errors = 0;

  // Shadow state of the assignment unit
  logic [15:0] cent_mem [int];
  logic [39:0] shadow_norm [NCL];
  logic [23:0] rate_sum [int];
  logic [21:0] rate_cnt [int];
  logic [39:0] dot_acc [NCL];
  logic [23:0] user_norm;
  logic [14:0] user_buf [$];
  bit user_ovf;
  logic [5:0] clusters_cfg;
  out_t assign_q [$];

  always #6 clk = ~clk;

  cosine_nearest_centroid_assign_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Q1.15 cosine from dot, centroid norm^2 and user norm^2, no square root
  function automatic logic [15:0] cos_q15(logic [39:0] d, logic [39:0] cn, logic [23:0] un);
    logic [127:0] nn, d2, rhs;
    logic [15:0] q, t;
    nn = 128'(cn) * 128'(un);
    d2 = 128'(d) * 128'(d);
    if (nn <= d2) return COS_ONE;
    rhs = d2 << 30;
    q = '0;
    for (int b = 14; b >= 0; b--) begin
      t = q | (16'd1 << b);
      if (nn * (128'(t) * 128'(t)) <= rhs) q = t;
    end
    return q;
  endfunction

  // Nearest-centroid pick, accumulator update and user reset
  function automatic out_t finish_user();
    int n, best, idx;
    bit found;
    logic [127:0] lhs, rhs;
    logic [15:0] cosv;
    out_t r;
    n = clusters_cfg;
    if (n < 1) n = 1;
    if (n > NCL) n = NCL;
    best = 0;
    found = 0;
    cosv = '0;
    for (int c = 0; c < n; c++) begin
      if (shadow_norm[c] == 0) continue;
      if (!found) begin
        best = c;
        found = 1;
      end else begin
        lhs = 128'(dot_acc[c]) * 128'(dot_acc[c]) * 128'(shadow_norm[best]);
        rhs = 128'(dot_acc[best]) * 128'(dot_acc[best]) * 128'(shadow_norm[c]);
        if (lhs > rhs) best = c;
      end
    end
    if (found && user_norm != 0) cosv = cos_q15(dot_acc[best], shadow_norm[best], user_norm);
    foreach (user_buf[i]) begin
      idx = best * NITEM + user_buf[i][14:3];
      if (!rate_sum.exists(idx)) begin
        rate_sum[idx] = '0;
        rate_cnt[idx] = '0;
      end
      if (rate_cnt[idx] < CNT_MAX && 25'(rate_sum[idx]) + user_buf[i][2:0] <= 25'(SUM_MAX)) begin
        rate_sum[idx] += user_buf[i][2:0];
        rate_cnt[idx] += 1;
      end
    end
    r = '0;
    r.result_kind = RES_ASSIGN;
    r.assigned_cluster = best[4:0];
    r.cosine = cosv;
    r.overflow = user_ovf;
    foreach (dot_acc[c]) dot_acc[c] = '0;
    user_norm = '0;
    user_buf.delete();
    user_ovf = 0;
    return r;
  endfunction

  // Apply one accepted transaction to the shadow state
  task automatic model_item(in_t x);
    int idx;
    logic [15:0] old;
    out_t r;
    idx = x.cluster * NITEM + x.item;
    case (x.kind)
      KIND_LOAD: begin
        old = cent_mem.exists(idx) ? cent_mem[idx] : 16'd0;
        shadow_norm[x.cluster] = shadow_norm[x.cluster]
                                 + 40'(x.centroid_value) * x.centroid_value
                                 - 40'(old) * old;
        cent_mem[idx] = x.centroid_value;
      end
      KIND_RATE: begin
        if (user_buf.size() >= NBUF) begin
          user_ovf = 1;
        end else begin
          for (int c = 0; c < NCL; c++) begin
            old = cent_mem.exists(c * NITEM + x.item) ? cent_mem[c * NITEM + x.item] : 16'd0;
            dot_acc[c] = dot_acc[c] + 40'(old) * x.rating;
          end
          user_norm = user_norm + x.rating * x.rating;
          user_buf.push_back({x.item, x.rating});
        end
        if (x.last) assign_q.push_back(finish_user());
      end
      KIND_READ: begin
        r = '0;
        r.result_kind = RES_READ;
        r.assigned_cluster = x.cluster;
        if (rate_cnt.exists(idx) && rate_cnt[idx] != 0)
          r.averaged_value = 16'((64'(rate_sum[idx]) << 13) / rate_cnt[idx]);
        assign_q.push_back(r);
      end
      default: begin
        rate_sum.delete();
        rate_cnt.delete();
      end
    endcase
  endtask

  // Send one transaction; random gaps unless in a quiet stretch
  task automatic send(in_t x);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = x;
    do @(posedge clk); while (in_stall);
    model_item(x);
    @(negedge clk);
  endtask

  function automatic in_t mk(logic [1:0] k, int cl, int it, int v, int r, bit l);
    in_t x;
    x.kind = k;
    x.cluster = cl[4:0];
    x.item = it[11:0];
    x.centroid_value = v[15:0];
    x.rating = r[2:0];
    x.last = l;
    return x;
  endfunction

  // Wait until every result is back and the block has gone quiet
  task automatic drain();
    in_valid = 1'b0;
    while (assign_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_count(logic [5:0] v);
    drain();
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    clusters_cfg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (assign_q.size() == 0) begin
        $error("unexpected result %p", out_data);
        errors++;
      end else begin
        e = assign_q.pop_front();
        if (out_data.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, out_data.result_kind);
          errors++;
        end
        if (out_data.assigned_cluster !== e.assigned_cluster) begin
          $error("assigned_cluster exp %0d got %0d", e.assigned_cluster,
                 out_data.assigned_cluster);
          errors++;
        end
        if (out_data.cosine !== e.cosine) begin
          $error("cosine exp %0d got %0d", e.cosine, out_data.cosine);
          errors++;
        end
        if (out_data.averaged_value !== e.averaged_value) begin
          $error("averaged_value exp %0d got %0d", e.averaged_value, out_data.averaged_value);
          errors++;
        end
        if (out_data.overflow !== e.overflow) begin
          $error("overflow exp %0d got %0d", e.overflow, out_data.overflow);
          errors++;
        end
      end
    end
  end

  // Output back-pressure
  always @(negedge clk) out_stall <= !quiet && $urandom_range(99) < 6;

  task automatic test_empty_and_ties();
    send(mk(KIND_RATE, 0, 1, 0, 3, 1));          // no centroid loaded
    send(mk(KIND_LOAD, 3, 1, 8192, 0, 0));
    send(mk(KIND_LOAD, 5, 1, 8192, 0, 0));
    send(mk(KIND_RATE, 0, 1, 0, 5, 1));          // tie, lowest index wins
    send(mk(KIND_RATE, 0, 1, 0, 0, 1));          // zero user norm
    send(mk(KIND_LOAD, 5, 2, 40960, 0, 0));
    send(mk(KIND_LOAD, 7, 4095, 65535, 0, 0));
    send(mk(KIND_LOAD, 7, 4095, 0, 0, 0));       // back to zero norm
    send(mk(KIND_LOAD, 31, 4095, 65535, 0, 0));
    send(mk(KIND_RATE, 0, 2, 0, 7, 0));
    send(mk(KIND_RATE, 0, 4095, 0, 4, 1));
    send(mk(KIND_READ, 3, 1, 0, 0, 0));
    send(mk(KIND_READ, 5, 2, 0, 0, 0));
    send(mk(KIND_READ, 31, 4095, 0, 0, 0));
  endtask

  task automatic test_buffer_full();
    for (int i = 0; i < NBUF + 4; i++)
      send(mk(KIND_RATE, 0, i % 8, 0, $urandom_range(7), i == NBUF + 3));
    send(mk(KIND_READ, 3, 1, 0, 0, 0));
  endtask

  task automatic test_clear();
    send(mk(KIND_CLEAR, 0, 0, 0, 0, 0));
    send(mk(KIND_READ, 3, 1, 0, 0, 0));
    send(mk(KIND_RATE, 0, 2, 0, 6, 1));
    send(mk(KIND_READ, 5, 2, 0, 0, 0));
  endtask

  task automatic test_count_extremes();
    write_count(6'd1);
    send(mk(KIND_RATE, 0, 2, 0, 3, 1));
    write_count(6'd0);
    send(mk(KIND_RATE, 0, 2, 0, 3, 1));
    write_count(6'd63);
    send(mk(KIND_RATE, 0, 4095, 0, 7, 1));
    write_count(6'd32);
    send(mk(KIND_RATE, 0, 4095, 0, 7, 1));
  endtask

  function automatic int pick_item();
    return ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(15);
  endfunction

  task automatic test_random();
    int sent, len, p;
    sent = 0;
    while (sent < 1400) begin
      if (sent % 300 < 8 && sent > 0) write_count($urandom_range(63));
      quiet = (sent >= 600 && sent < 800);
      p = $urandom_range(99);
      if (p < 30) begin
        send(mk(KIND_LOAD, $urandom_range(31), pick_item(),
                ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(40960),
                0, 0));
        sent++;
      end else if (p < 88) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send(mk(KIND_RATE, $urandom_range(31), pick_item(), $urandom_range(65535),
                  ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(5),
                  i == len - 1));
        sent += len;
      end else begin
        send(mk(KIND_READ, $urandom_range(31), pick_item(), $urandom_range(65535),
                $urandom_range(7), $urandom_range(1)));
        sent++;
      end
    end
    quiet = 0;
  endtask

  initial begin
    clusters_cfg = CNT_RESET;
    foreach (shadow_norm[c]) shadow_norm[c] = '0;
    foreach (dot_acc[c]) dot_acc[c] = '0;
    user_norm = '0;
    user_ovf = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_and_ties();
    test_buffer_full();
    test_count_extremes();
    test_clear();
    test_random();
    drain();
    repeat (1000) @(posedge clk);
    if (errors == 0 && assign_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Run limit
  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

endmodule
